>>> rtl/core/point_attractor_particle_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point attractor particle step block
// Shorthand for clocked concurrent checks. The using scope must provide
// signals named clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef POINT_ATTRACTOR_PARTICLE_STEP_MACROS_SVH
`define POINT_ATTRACTOR_PARTICLE_STEP_MACROS_SVH

// Check a consequence in the same cycle as its condition
`define PAP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its condition
`define PAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_pkg
// Shared types, register indexes and constants of the point attractor
// particle step pipeline.
// ----------------------------------------------------------------------------
package pap_pkg;

	// Register indexes on the configuration channel
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLE_X         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLE_Y         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLE_Z         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLE_MASS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_RADIUS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd5;

	// 4 * 0.0015 * 80000, folded into one gain
	localparam logic [8:0] GAIN = 9'd480;
	// 1e-5 in Q.32
	localparam logic [63:0] EPS_Q32 = 64'd42950;

	// Iteration counts of the digit-serial units
	localparam int SQRT_STEPS = 32;
	localparam int ACC_W      = 49;
	localparam int DIV_STEPS  = ACC_W;

	// Acceleration ceiling, 2^48 raw
	localparam logic [ACC_W-1:0] ACC_LIMIT = {1'b1, {(ACC_W-1){1'b0}}};

	// Per-particle data carried along the whole pipe
	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic             live;
		logic             captured;
	} item_t;

	// Saturate a signed 50-bit value to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic [49:0] v);
		logic [31:0] r;
		if (!v[49] && (|v[48:31])) begin
			r = 32'h7FFF_FFFF;
		end else if (v[49] && !(&v[48:31])) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/point_attractor_particle_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_attractor_particle_step
// Advances one particle per request by one semi-implicit Euler step toward
// a configured point mass, in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one particle per request: six Q16.16 words in tdata and
//   the active flag in tuser. m_axis returns one updated particle for every
//   request, in order, with still_active and was_captured in tuser.
//   The cfg channel writes the attractor position, mass, capture radius and
//   time step; cfg_ready is always high. Write it only while the pipe is
//   empty.
//   One request enters per clock while m_axis does not stall: the whole
//   datapath is a 143-stage pipe from acceptance to the output register,
//   made of a 32-step square root, a 49-step restoring divider for the
//   force, and three 49-step restoring dividers for the direction.
//   When m_axis stalls, the whole pipe freezes with the output register and
//   s_axis_tready drops in the same cycle; nothing is lost or repeated.
//   Reset clears every stage valid bit and the configuration registers.
// ----------------------------------------------------------------------------
module point_attractor_particle_step (
	input  logic         clk,
	input  logic         arst_n,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each, lowest first)
	input  logic [191:0] s_axis_tdata,
	// is_active
	input  logic [0:0]   s_axis_tuser,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
	output logic [191:0] m_axis_tdata,
	// still_active, was_captured
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [pap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int SQ = pap_pkg::SQRT_STEPS;
	localparam int DV = pap_pkg::DIV_STEPS;
	localparam int AW = pap_pkg::ACC_W;

	// Configuration registers
	logic [2:0][31:0] hole_q;
	logic [31:0]      mass_q;
	logic [30:0]      radius_q;
	logic [15:0]      tstep_q;
	logic [61:0]      rad_sq_q;
	logic [40:0]      gain_q;

	logic adv;

	// Input and first stages
	pap_pkg::item_t   in_item;
	logic             v_s1, v_s2;
	pap_pkg::item_t   it_s1, it_s2;
	logic [2:0][63:0] sq_s2;
	logic [65:0]      dist_sum;
	logic [63:0]      dist_sat;
	logic             cap_hit;
	pap_pkg::item_t   sq_load;

	// Square root
	logic             sq_v    [0:SQ];
	pap_pkg::item_t   sq_it   [0:SQ];
	logic [63:0]      sq_x    [0:SQ];
	logic [33:0]      sq_rem  [0:SQ];
	logic [31:0]      sq_root [0:SQ];
	logic [33:0]      sq_rem_n  [0:SQ-1];
	logic [31:0]      sq_root_n [0:SQ-1];

	// Cube of the distance
	logic             v_e1, v_e2;
	pap_pkg::item_t   it_e1, it_e2;
	logic [31:0]      d_e1, d_e2;
	logic [63:0]      d2_e1, u_e2;
	logic [47:0]      t_e2;
	logic [63:0]      e2_tlo;
	logic [63:0]      den_val;

	// Force divider
	logic             dv_v   [0:DV];
	pap_pkg::item_t   dv_it  [0:DV];
	logic [31:0]      dv_d   [0:DV];
	logic [40:0]      dv_p   [0:DV];
	logic [63:0]      dv_den [0:DV];
	logic [63:0]      dv_rem [0:DV];
	logic [AW-1:0]    dv_q   [0:DV];
	logic             dv_ovf [0:DV];
	logic [63:0]      dv_rem_n [0:DV-1];
	logic [AW-1:0]    dv_q_n   [0:DV-1];
	logic             dv_ovf_n [0:DV-1];

	// Clamp and direction products
	logic             v_ac, v_m1;
	pap_pkg::item_t   it_ac, it_m1;
	logic [31:0]      d_ac, d_m1;
	logic [AW-1:0]    acc_ac;
	logic [2:0][56:0] lo_m1;
	logic [2:0][55:0] hi_m1;

	// Direction dividers
	logic             qd_v   [0:DV];
	pap_pkg::item_t   qd_it  [0:DV];
	logic [31:0]      qd_d   [0:DV];
	logic [2:0][80:0] qd_num [0:DV];
	logic [2:0][31:0] qd_rem [0:DV];
	logic [2:0][AW-1:0] qd_q [0:DV];
	logic [2:0][31:0] qd_rem_n [0:DV-1];
	logic [2:0][AW-1:0] qd_q_n [0:DV-1];
	logic [2:0][80:0] qd_num0;

	// Velocity and position update
	logic             v_v1, v_v2, v_p1;
	pap_pkg::item_t   it_v1, it_v2, it_p1;
	logic [2:0][48:0] dv_v1;
	logic [2:0][48:0] v1_dvn;
	logic [2:0][31:0] nvel_v2, nvel_p1, v2_nvel_n;
	logic [2:0][31:0] pm_p1, p1_pm_n;
	logic [2:0][31:0] npos_n;

	// Output register
	logic             out_v_q;
	logic [191:0]     out_data_q;
	logic [1:0]       out_user_q;

	// Freeze the whole pipe while a result waits unaccepted
	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_q   <= '0;
			mass_q   <= '0;
			radius_q <= '0;
			tstep_q  <= '0;
			rad_sq_q <= '0;
			gain_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pap_pkg::CFG_HOLE_X:         hole_q[0] <= cfg_data;
					pap_pkg::CFG_HOLE_Y:         hole_q[1] <= cfg_data;
					pap_pkg::CFG_HOLE_Z:         hole_q[2] <= cfg_data;
					pap_pkg::CFG_HOLE_MASS:      mass_q    <= cfg_data;
					pap_pkg::CFG_CAPTURE_RADIUS: radius_q  <= cfg_data[30:0];
					pap_pkg::CFG_TIME_STEP:      tstep_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			// Derived constants follow in the next cycle
			rad_sq_q <= 62'(radius_q) * 62'(radius_q);
			gain_q   <= 41'(mass_q) * 41'(pap_pkg::GAIN);
		end
	end

	// Unpack the request and form the difference to the attractor
	always_comb begin
		logic [32:0] diff;
		logic [32:0] abs33;
		in_item = '0;
		for (int i = 0; i < 3; i++) begin
			in_item.pos[i] = s_axis_tdata[32*i +: 32];
			in_item.vel[i] = s_axis_tdata[96 + 32*i +: 32];
			diff  = {hole_q[i][31], hole_q[i]} - {in_item.pos[i][31], in_item.pos[i]};
			abs33 = diff[32] ? (33'd0 - diff) : diff;
			in_item.neg[i] = diff[32];
			in_item.mag[i] = abs33[31:0];
		end
		in_item.live     = s_axis_tuser[0];
		in_item.captured = 1'b0;
	end

	// Sum the squares with saturation and test the capture radius
	always_comb begin
		dist_sum = 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);
		dist_sat = (|dist_sum[65:64]) ? '1 : dist_sum[63:0];
		cap_hit  = it_s2.live && (dist_sat < 64'(rad_sq_q));
		sq_load          = it_s2;
		sq_load.live     = it_s2.live && !cap_hit;
		sq_load.captured = cap_hit;
	end

	// One result bit of the square root per stage
	always_comb begin
		logic [35:0] rsh;
		logic [35:0] trial;
		for (int k = 0; k < SQ; k++) begin
			rsh   = {sq_rem[k], sq_x[k][2*(SQ-1-k)+1], sq_x[k][2*(SQ-1-k)]};
			trial = {2'b00, sq_root[k], 2'b01};
			if (rsh >= trial) begin
				sq_rem_n[k]  = 34'(rsh - trial);
				sq_root_n[k] = {sq_root[k][30:0], 1'b1};
			end else begin
				sq_rem_n[k]  = rsh[33:0];
				sq_root_n[k] = {sq_root[k][30:0], 1'b0};
			end
		end
	end

	// Cube of the distance plus epsilon, saturated
	always_comb begin
		logic [64:0] vsum;
		logic [64:0] esum;
		logic [63:0] base;
		e2_tlo = 64'(d2_e1[31:0]) * 64'(d_e1);
		vsum   = {1'b0, u_e2[47:0], 16'd0} + 65'(t_e2);
		if (|u_e2[63:48]) begin
			base = '1;
		end else begin
			base = vsum[64] ? '1 : vsum[63:0];
		end
		esum    = {1'b0, base} + {1'b0, pap_pkg::EPS_Q32};
		den_val = esum[64] ? '1 : esum[63:0];
	end

	// One quotient bit of the force per stage
	always_comb begin
		logic [64:0] r2;
		logic [72:0] num;
		logic        nb;
		logic        ge;
		for (int k = 0; k < DV; k++) begin
			num = {dv_p[k], 32'd0};
			nb  = num[DV - 1 - k];
			r2 = {dv_rem[k], nb};
			ge = r2 >= {1'b0, dv_den[k]};
			dv_rem_n[k] = ge ? 64'(r2 - {1'b0, dv_den[k]}) : r2[63:0];
			dv_q_n[k]   = {dv_q[k][AW-2:0], ge};
			dv_ovf_n[k] = (k == 0) ? (dv_rem[k] >= dv_den[k]) : dv_ovf[k];
		end
	end

	// Join the partial products of force times axis distance
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qd_num0[i] = {hi_m1[i], 25'd0} + 81'(lo_m1[i]);
		end
	end

	// One quotient bit of each direction component per stage
	always_comb begin
		logic [32:0] r2;
		logic        ge;
		for (int k = 0; k < DV; k++) begin
			for (int i = 0; i < 3; i++) begin
				r2 = {qd_rem[k][i], qd_num[k][i][DV - 1 - k]};
				ge = r2 >= {1'b0, qd_d[k]};
				qd_rem_n[k][i] = ge ? 32'(r2 - {1'b0, qd_d[k]}) : r2[31:0];
				qd_q_n[k][i]   = {qd_q[k][i][AW-2:0], ge};
			end
		end
	end

	// Scale acceleration by dt, update velocity, then position
	always_comb begin
		logic [AW-1:0] amag;
		logic [64:0]   vprod;
		logic [49:0]   ext;
		logic [49:0]   sum;
		logic [31:0]   nmag;
		logic [47:0]   pprod;
		for (int i = 0; i < 3; i++) begin
			amag      = (qd_d[DV] == 32'd0) ? '0 : qd_q[DV][i];
			vprod     = 65'(amag) * 65'(tstep_q);
			v1_dvn[i] = vprod[64:16];

			ext = {{18{it_v1.vel[i][31]}}, it_v1.vel[i]};
			sum = it_v1.neg[i] ? (ext - {1'b0, dv_v1[i]}) : (ext + {1'b0, dv_v1[i]});
			v2_nvel_n[i] = pap_pkg::sat32(sum);

			nmag  = nvel_v2[i][31] ? (32'd0 - nvel_v2[i]) : nvel_v2[i];
			pprod = 48'(nmag) * 48'(tstep_q);
			p1_pm_n[i] = pprod[47:16];

			ext = {{18{it_p1.pos[i][31]}}, it_p1.pos[i]};
			sum = nvel_p1[i][31] ? (ext - {18'd0, pm_p1[i]}) : (ext + {18'd0, pm_p1[i]});
			npos_n[i] = pap_pkg::sat32(sum);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k <= SQ; k++) sq_v[k] <= 1'b0;
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			for (int k = 0; k <= DV; k++) dv_v[k] <= 1'b0;
			v_ac <= 1'b0;
			v_m1 <= 1'b0;
			for (int k = 0; k <= DV; k++) qd_v[k] <= 1'b0;
			v_v1    <= 1'b0;
			v_v2    <= 1'b0;
			v_p1    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= s_axis_tvalid;
			v_s2    <= v_s1;
			sq_v[0] <= v_s2;
			for (int k = 0; k < SQ; k++) sq_v[k+1] <= sq_v[k];
			v_e1    <= sq_v[SQ];
			v_e2    <= v_e1;
			dv_v[0] <= v_e2;
			for (int k = 0; k < DV; k++) dv_v[k+1] <= dv_v[k];
			v_ac    <= dv_v[DV];
			v_m1    <= v_ac;
			qd_v[0] <= v_m1;
			for (int k = 0; k < DV; k++) qd_v[k+1] <= qd_v[k];
			v_v1    <= qd_v[DV];
			v_v2    <= v_v1;
			v_p1    <= v_v2;
			out_v_q <= v_p1;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			// distance squared
			it_s1 <= in_item;
			it_s2 <= it_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 64'(it_s1.mag[i]) * 64'(it_s1.mag[i]);
			end

			// load square root, mark captured particles not live so they pass through
			sq_it[0]   <= sq_load;
			sq_x[0]    <= dist_sat;
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			for (int k = 0; k < SQ; k++) begin
				sq_it[k+1]   <= sq_it[k];
				sq_x[k+1]    <= sq_x[k];
				sq_rem[k+1]  <= sq_rem_n[k];
				sq_root[k+1] <= sq_root_n[k];
			end

			// cube of distance
			it_e1 <= sq_it[SQ];
			d_e1  <= sq_root[SQ];
			d2_e1 <= 64'(sq_root[SQ]) * 64'(sq_root[SQ]);
			it_e2 <= it_e1;
			d_e2  <= d_e1;
			u_e2  <= 64'(d2_e1[63:32]) * 64'(d_e1);
			t_e2  <= e2_tlo[63:16];

			// force divider
			dv_it[0]  <= it_e2;
			dv_d[0]   <= d_e2;
			dv_p[0]   <= gain_q;
			dv_den[0] <= den_val;
			dv_rem[0] <= 64'(gain_q[40:17]);
			dv_q[0]   <= '0;
			dv_ovf[0] <= 1'b0;
			for (int k = 0; k < DV; k++) begin
				dv_it[k+1]  <= dv_it[k];
				dv_d[k+1]   <= dv_d[k];
				dv_p[k+1]   <= dv_p[k];
				dv_den[k+1] <= dv_den[k];
				dv_rem[k+1] <= dv_rem_n[k];
				dv_q[k+1]   <= dv_q_n[k];
				dv_ovf[k+1] <= dv_ovf_n[k];
			end

			// clamp the force, then multiply by each axis distance
			it_ac  <= dv_it[DV];
			d_ac   <= dv_d[DV];
			acc_ac <= (dv_ovf[DV] || (dv_q[DV][AW-1] && (|dv_q[DV][AW-2:0])))
				? pap_pkg::ACC_LIMIT : dv_q[DV];
			it_m1 <= it_ac;
			d_m1  <= d_ac;
			for (int i = 0; i < 3; i++) begin
				lo_m1[i] <= 57'(acc_ac[24:0]) * 57'(it_ac.mag[i]);
				hi_m1[i] <= 56'(acc_ac[AW-1:25]) * 56'(it_ac.mag[i]);
			end

			// direction dividers
			qd_it[0]  <= it_m1;
			qd_d[0]   <= d_m1;
			qd_num[0] <= qd_num0;
			qd_q[0]   <= '0;
			for (int i = 0; i < 3; i++) begin
				qd_rem[0][i] <= qd_num0[i][80:49];
			end
			for (int k = 0; k < DV; k++) begin
				qd_it[k+1]  <= qd_it[k];
				qd_d[k+1]   <= qd_d[k];
				qd_num[k+1] <= qd_num[k];
				qd_rem[k+1] <= qd_rem_n[k];
				qd_q[k+1]   <= qd_q_n[k];
			end

			// integrate
			it_v1   <= qd_it[DV];
			dv_v1   <= v1_dvn;
			it_v2   <= it_v1;
			nvel_v2 <= v2_nvel_n;
			it_p1   <= it_v2;
			nvel_p1 <= nvel_v2;
			pm_p1   <= p1_pm_n;

			// select computed or passed-through particle
			if (it_p1.live) begin
				out_data_q <= {nvel_p1, npos_n};
			end else begin
				out_data_q <= {it_p1.vel, it_p1.pos};
			end
			out_user_q <= {it_p1.captured, it_p1.live};
		end
	end

endmodule

>>> rtl/core/pap_port_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pap_port_check
// Port-level checks of the point attractor particle step block, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "point_attractor_particle_step_macros.svh"

module pap_port_check (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [191:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic         cfg_valid,
	input logic         cfg_ready
);

	// Hold a stalled result
	`PAP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// A captured particle never survives
	`PAP_ASSERT_NOW(a_capture_retires, m_axis_tvalid, !(m_axis_tuser[1] && m_axis_tuser[0]), "captured particle still active")

	// Take requests whenever the output side is free
	`PAP_ASSERT_NOW(a_ready_free, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked with free output")

	// Never refuse a configuration write
	`PAP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind point_attractor_particle_step pap_port_check u_pap_port_check (.*);
